// ----- hdl/thermistor_divider_to_celsius_unit_macros.svh -----
// Assertion macros shared by the thermistor conversion unit.
`ifndef THERMISTOR_DIVIDER_TO_CELSIUS_UNIT_MACROS_SVH
`define THERMISTOR_DIVIDER_TO_CELSIUS_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define THDC_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define THDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/thdc_pkg.sv -----
// Package with types, constants and codes of the thermistor conversion unit.
`default_nettype none

package thdc_pkg;

    localparam int SUPPLY_W   = 13;
    localparam int TEMP_W     = 17;
    localparam int STATUS_W   = 2;
    localparam int DIV_OHM_W  = 20;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RD_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RD_HIGH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = 4'd3;

    localparam logic [DIV_OHM_W-1:0] DIVIDER_RST = 20'd10000;
    localparam logic [COEF_W-1:0]    COEF_A_RST  = 32'd1241511370;
    localparam logic [COEF_W-1:0]    COEF_B_RST  = 32'd257423160;
    localparam logic [COEF_W-1:0]    COEF_C_RST  = 32'd96399;

    // Resistance quotient: 33-bit product with 24 fraction bits.
    localparam int R_FRAC     = 24;
    localparam int R_W        = 57;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = R_W / DIV_BITS;

    // Logarithm.
    localparam int M_W                     = 63;
    localparam int LOG_STEPS               = 30;
    localparam int LOG_STEPS_PER_STAGE_DEF = 2;
    localparam logic [63:0] LN2_Q62        = 64'h2C5C85FDF473DE6A;
    localparam logic [26:0] LN2_Q27        = 27'd93032640;
    localparam int MAG_W                   = 32;

    // Inverse temperature and final division.
    localparam int INV_W  = 50;
    localparam int NUM_W  = 49;
    localparam int QUO_W  = 17;
    localparam logic [NUM_W-1:0] NUM_CENTI = 49'd100 << 40;
    localparam logic [17:0] KELVIN_CENTI   = 18'd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd65535;

    typedef struct packed {
        logic                vld;
        logic [STATUS_W-1:0] st;
    } t_tag;

endpackage

`default_nettype wire

// ----- hdl/thdc_in_if.sv -----
// Input sample channel of the thermistor conversion unit.
`default_nettype none

interface thdc_in_if;
    import thdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SUPPLY_W-1:0] supply_mv;
    logic [SUPPLY_W-1:0] read_mv;

    modport source (output valid, output supply_mv, output read_mv, input ready);
    modport sink   (input valid, input supply_mv, input read_mv, output ready);
endinterface

`default_nettype wire

// ----- hdl/thdc_out_if.sv -----
// Result channel of the thermistor conversion unit.
`default_nettype none

interface thdc_out_if;
    import thdc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_centi_c;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output temp_centi_c, output status, input ready);
    modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/thdc_cfg_if.sv -----
// Configuration write channel of the thermistor conversion unit.
`default_nettype none

interface thdc_cfg_if;
    import thdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/thermistor_divider_to_celsius_unit.sv -----
// Top level of the thermistor divider to Celsius conversion unit.
// Throughput: one transaction per cycle, set by the fully pipelined divider, log and
// reciprocal; the pipeline halts only while its last stage and the output are both full.
// Reset is synchronous and active low: it clears every valid bit and loads the
// configuration registers with their default values.
`default_nettype none
`include "thermistor_divider_to_celsius_unit_macros.svh"

module thermistor_divider_to_celsius_unit
    import thdc_pkg::*;
#(
    parameter int LOG_STEPS_PER_STAGE = LOG_STEPS_PER_STAGE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thdc_cfg_if.sink   i_cfg,
    thdc_in_if.sink    i_in,
    thdc_out_if.source o_out
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond
    // the register list is ignored.
    // ------------------------------------------------------------------
    logic [DIV_OHM_W-1:0] r_divider;
    logic [COEF_W-1:0]    r_coef_a;
    logic [COEF_W-1:0]    r_coef_b;
    logic [COEF_W-1:0]    r_coef_c;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= DIVIDER_RST;
            r_coef_a  <= COEF_A_RST;
            r_coef_b  <= COEF_B_RST;
            r_coef_c  <= COEF_C_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_DIVIDER: r_divider <= i_cfg.data[DIV_OHM_W-1:0];
                REG_COEF_A:  r_coef_a  <= i_cfg.data[COEF_W-1:0];
                REG_COEF_B:  r_coef_b  <= i_cfg.data[COEF_W-1:0];
                REG_COEF_C:  r_coef_c  <= i_cfg.data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves together on w_en. The pipeline only
    // halts when its last stage holds a result and the output register
    // is still full, so an input transaction is taken while a finished
    // result waits as long as there is a bubble in front of it.
    // ------------------------------------------------------------------
    logic w_en;
    logic w_last_vld;
    logic r_out_vld;

    assign w_en       = !w_last_vld || !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // ------------------------------------------------------------------
    // Stage 0: input checks and the product divider * (supply - read).
    // The product is placed above 24 fraction bits to form the dividend.
    // ------------------------------------------------------------------
    typedef struct packed {
        t_tag                tag;
        logic [SUPPLY_W-1:0] rd;
        logic [SUPPLY_W-1:0] rem;
        logic [R_W-1:0]      q;
        logic [R_W-1:0]      num;
    } t_dv;

    t_dv                 r_s0, c_s0;
    logic [SUPPLY_W-1:0] c_diff;
    logic [R_W-R_FRAC-1:0] c_prod;

    always_comb begin
        c_diff      = i_in.supply_mv - i_in.read_mv;
        c_prod      = (R_W-R_FRAC)'(r_divider) * (R_W-R_FRAC)'(c_diff);
        c_s0.tag.vld = i_in.valid;
        if (i_in.read_mv == '0) begin
            c_s0.tag.st = ST_RD_ZERO;
        end else if (i_in.read_mv >= i_in.supply_mv) begin
            c_s0.tag.st = ST_RD_HIGH;
        end else begin
            c_s0.tag.st = ST_OK;
        end
        c_s0.rd  = i_in.read_mv;
        c_s0.rem = '0;
        c_s0.q   = '0;
        c_s0.num = {c_prod, {R_FRAC{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.tag.vld <= 1'b0;
        end else if (w_en) begin
            r_s0 <= c_s0;
        end
    end

    // ------------------------------------------------------------------
    // Resistance divider: restoring long division, a few quotient bits per
    // stage. The remainder stays below the read value, so it is narrow.
    // ------------------------------------------------------------------
    t_dv r_dv [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        t_dv               c_prev, c_next;
        logic [SUPPLY_W:0] c_try;

        if (j == 0) begin : g_first
            assign c_prev = r_s0;
        end else begin : g_rest
            assign c_prev = r_dv[j-1];
        end

        always_comb begin
            c_next = c_prev;
            c_try  = '0;
            for (int b = 0; b < DIV_BITS; b++) begin
                c_try    = {c_next.rem, c_prev.num[R_W-1-(j*DIV_BITS+b)]};
                c_next.q = {c_next.q[R_W-2:0], 1'b0};
                if (c_try >= {1'b0, c_prev.rd}) begin
                    c_next.rem  = SUPPLY_W'(c_try - {1'b0, c_prev.rd});
                    c_next.q[0] = 1'b1;
                end else begin
                    c_next.rem = c_try[SUPPLY_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j].tag.vld <= 1'b0;
            end else if (w_en) begin
                r_dv[j] <= c_next;
            end
        end
    end

    // A zero resistance has no logarithm; it saturates high.
    t_tag w_log_in_tag;
    always_comb begin
        w_log_in_tag = r_dv[DIV_STAGES-1].tag;
        if (w_log_in_tag.st == ST_OK && r_dv[DIV_STAGES-1].q == '0) begin
            w_log_in_tag.st = ST_SAT;
        end
    end

    // ------------------------------------------------------------------
    // Natural logarithm of the resistance, signed Q27, as sign and magnitude.
    // ------------------------------------------------------------------
    t_tag             w_log_tag;
    logic [MAG_W-1:0] w_log_mag;
    logic             w_log_neg;

    thdc_log #(
        .STEPS_PER_STAGE (LOG_STEPS_PER_STAGE)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_log_in_tag),
        .i_r     (r_dv[DIV_STAGES-1].q),
        .o_tag   (w_log_tag),
        .o_mag   (w_log_mag),
        .o_neg   (w_log_neg)
    );

    // ------------------------------------------------------------------
    // Steinhart-Hart polynomial on magnitudes, every product truncated to
    // 27 fraction bits. Wide products are cut into two partial products
    // and recombined in the following stage.
    // ------------------------------------------------------------------
    t_tag        r_p1_tag;
    logic [36:0] r_p1_bl;
    logic [36:0] r_p1_l2;
    logic [31:0] r_p1_mag;
    logic        r_p1_neg;
    logic [63:0] c_p1_bl;
    logic [63:0] c_p1_l2;

    assign c_p1_bl = 64'(r_coef_b) * 64'(w_log_mag);
    assign c_p1_l2 = 64'(w_log_mag) * 64'(w_log_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p1_tag <= w_log_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_bl  <= c_p1_bl[63:27];
            r_p1_l2  <= c_p1_l2[63:27];
            r_p1_mag <= w_log_mag;
            r_p1_neg <= w_log_neg;
        end
    end

    // L^3 partial products.
    t_tag        r_p2_tag;
    logic [63:0] r_p2_l3a;
    logic [36:0] r_p2_l3b;
    logic [36:0] r_p2_bl;
    logic        r_p2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p2_tag <= r_p1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_l3a <= 64'(r_p1_l2[31:0]) * 64'(r_p1_mag);
            r_p2_l3b <= 37'(r_p1_l2[36:32]) * 37'(r_p1_mag);
            r_p2_bl  <= r_p1_bl;
            r_p2_neg <= r_p1_neg;
        end
    end

    // L^3 recombined.
    t_tag        r_p3_tag;
    logic [41:0] r_p3_l3;
    logic [36:0] r_p3_bl;
    logic        r_p3_neg;
    logic [68:0] c_p3_sum;

    assign c_p3_sum = {r_p2_l3b, 32'b0} + 69'(r_p2_l3a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p3_tag <= r_p2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_l3  <= c_p3_sum[68:27];
            r_p3_bl  <= r_p2_bl;
            r_p3_neg <= r_p2_neg;
        end
    end

    // C * L^3 partial products.
    t_tag        r_p4_tag;
    logic [52:0] r_p4_cla;
    logic [52:0] r_p4_clb;
    logic [36:0] r_p4_bl;
    logic        r_p4_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p4_tag <= r_p3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_cla <= 53'(r_coef_c) * 53'(r_p3_l3[20:0]);
            r_p4_clb <= 53'(r_coef_c) * 53'(r_p3_l3[41:21]);
            r_p4_bl  <= r_p3_bl;
            r_p4_neg <= r_p3_neg;
        end
    end

    // C * L^3 recombined.
    t_tag        r_p5_tag;
    logic [46:0] r_p5_cl;
    logic [36:0] r_p5_bl;
    logic        r_p5_neg;
    logic [73:0] c_p5_sum;

    assign c_p5_sum = {r_p4_clb, 21'b0} + 74'(r_p4_cla);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p5_tag <= r_p4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p5_cl  <= c_p5_sum[73:27];
            r_p5_bl  <= r_p4_bl;
            r_p5_neg <= r_p4_neg;
        end
    end

    // B*L + C*L^3.
    t_tag        r_p6_tag;
    logic [47:0] r_p6_s;
    logic        r_p6_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p6_tag <= r_p5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p6_s   <= 48'(r_p5_bl) + 48'(r_p5_cl);
            r_p6_neg <= r_p5_neg;
        end
    end

    // Inverse temperature 1/T = A +/- (B*L + C*L^3), signed Q9.40.
    t_tag                    r_p7_tag;
    logic signed [INV_W-1:0] r_p7_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p7_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p7_tag <= r_p6_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_p6_neg) begin
                r_p7_inv <= $signed(INV_W'(r_coef_a)) - $signed(INV_W'(r_p6_s));
            end else begin
                r_p7_inv <= $signed(INV_W'(r_coef_a)) + $signed(INV_W'(r_p6_s));
            end
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal: round(100 * 2^40 / inv). A non-positive inverse
    // saturates. The dividend includes half the divisor for rounding.
    // ------------------------------------------------------------------
    typedef struct packed {
        t_tag             tag;
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] dv;
        logic [QUO_W-1:0] q;
    } t_qd;

    t_qd r_p8, c_p8;

    always_comb begin
        c_p8.tag = r_p7_tag;
        if (c_p8.tag.st == ST_OK && (r_p7_inv[INV_W-1] || r_p7_inv == '0)) begin
            c_p8.tag.st = ST_SAT;
        end
        c_p8.dv  = r_p7_inv[NUM_W-1:0];
        c_p8.rem = NUM_CENTI + NUM_W'(r_p7_inv[NUM_W-1:1]);
        c_p8.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p8.tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p8 <= c_p8;
        end
    end

    // A quotient of 2^17 or more lies far above the output range.
    t_qd r_p9, c_p9;

    always_comb begin
        c_p9 = r_p8;
        if (c_p9.tag.st == ST_OK
            && {{QUO_W{1'b0}}, r_p8.rem} >= {r_p8.dv, {QUO_W{1'b0}}}) begin
            c_p9.tag.st = ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p9.tag.vld <= 1'b0;
        end else if (w_en) begin
            r_p9 <= c_p9;
        end
    end

    // One quotient bit per stage, most significant first.
    t_qd r_qd [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_quo
        t_qd                    c_prev, c_next;
        logic [NUM_W+QUO_W-1:0] c_shdv;

        if (s == 0) begin : g_first
            assign c_prev = r_p9;
        end else begin : g_rest
            assign c_prev = r_qd[s-1];
        end

        always_comb begin
            c_next   = c_prev;
            c_shdv   = {{QUO_W{1'b0}}, c_prev.dv} << (QUO_W - 1 - s);
            c_next.q = {c_prev.q[QUO_W-2:0], 1'b0};
            if ({{QUO_W{1'b0}}, c_prev.rem} >= c_shdv) begin
                c_next.rem  = NUM_W'({{QUO_W{1'b0}}, c_prev.rem} - c_shdv);
                c_next.q[0] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qd[s].tag.vld <= 1'b0;
            end else if (w_en) begin
                r_qd[s] <= c_next;
            end
        end
    end

    assign w_last_vld = r_qd[QUO_W-1].tag.vld;

    // ------------------------------------------------------------------
    // Output register: Kelvin offset, final saturation and the fixed
    // results of the error cases.
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [STATUS_W-1:0]      r_out_st;
    logic signed [TEMP_W:0]   c_temp;
    logic signed [TEMP_W-1:0] n_out_temp;
    logic [STATUS_W-1:0]      n_out_st;

    always_comb begin
        c_temp     = $signed({1'b0, r_qd[QUO_W-1].q}) - $signed(KELVIN_CENTI);
        n_out_st   = r_qd[QUO_W-1].tag.st;
        n_out_temp = '0;
        case (r_qd[QUO_W-1].tag.st)
            ST_OK: begin
                if (c_temp > $signed((TEMP_W+1)'(TEMP_MAX))) begin
                    n_out_st   = ST_SAT;
                    n_out_temp = TEMP_MAX;
                end else begin
                    n_out_temp = c_temp[TEMP_W-1:0];
                end
            end
            ST_SAT:  n_out_temp = TEMP_MAX;
            default: n_out_temp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || o_out.ready) begin
            r_out_vld <= w_last_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || o_out.ready) begin
            r_out_temp <= n_out_temp;
            r_out_st   <= n_out_st;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.temp_centi_c = r_out_temp;
    assign o_out.status       = r_out_st;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `THDC_ASSERT_HOLDS(a_err_temp_zero, i_clk, i_rst_n, (o_out.valid && (o_out.status == ST_RD_ZERO || o_out.status == ST_RD_HIGH)) |-> (o_out.temp_centi_c == '0), "error status with nonzero temperature")
    `THDC_ASSERT_HOLDS(a_sat_temp_max, i_clk, i_rst_n, (o_out.valid && o_out.status == ST_SAT) |-> (o_out.temp_centi_c == TEMP_MAX), "saturated status without full-scale temperature")
    `THDC_ASSERT_NEXT(a_stall_keeps_last, i_clk, i_rst_n, !w_en && w_last_vld, w_last_vld && $stable(r_qd[QUO_W-1].q), "last pipeline stage lost or changed during a stall")

endmodule

`default_nettype wire

// ----- hdl/thdc_log.sv -----
// Pipelined natural logarithm of the thermistor resistance.
`default_nettype none

module thdc_log
    import thdc_pkg::*;
#(
    parameter int STEPS_PER_STAGE = LOG_STEPS_PER_STAGE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_tag             i_tag,
    input  logic [R_W-1:0]   i_r,
    output t_tag             o_tag,
    output logic [MAG_W-1:0] o_mag,
    output logic             o_neg
);

    localparam int ITER_STAGES = LOG_STEPS / STEPS_PER_STAGE;
    localparam int SC_W        = 6;
    localparam int LN_TERMS    = 62;
    localparam int EXP_OFS     = M_W - 1 - R_FRAC;
    localparam logic [65:0] LN_RND = 66'd1 << 34;

    typedef struct packed {
        t_tag            tag;
        logic [M_W-1:0]  m;
        logic [63:0]     sum;
        logic [SC_W-1:0] sc;
    } t_lg;

    // Table of ln(1 + 2^-k) in Q62, from the truncated alternating series.
    logic [63:0] w_chain [1:LOG_STEPS][0:LN_TERMS];

    for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_tab
        assign w_chain[k][0] = '0;
        for (genvar n = 1; n <= LN_TERMS; n++) begin : g_term
            localparam int NDIV = n;
            localparam int SH   = (k * n <= LN_TERMS) ? LN_TERMS - k * n : 0;
            localparam logic [63:0] TERM = (k * n <= LN_TERMS) ? ((64'd1 << SH) / NDIV) : 64'd0;
            if (n % 2 == 1) begin : g_add
                assign w_chain[k][n] = w_chain[k][n-1] + TERM;
            end else begin : g_sub
                assign w_chain[k][n] = w_chain[k][n-1] - TERM;
            end
        end
    end

    // Normalisation, first half: shifts of 32, 16 and 8.
    t_lg r_n1, c_n1;
    always_comb begin
        c_n1.tag = i_tag;
        c_n1.sum = '0;
        c_n1.m   = {{(M_W-R_W){1'b0}}, i_r};
        c_n1.sc  = '0;
        if (c_n1.m[M_W-1 -: 32] == '0) begin
            c_n1.m  = c_n1.m << 32;
            c_n1.sc = c_n1.sc + 6'd32;
        end
        if (c_n1.m[M_W-1 -: 16] == '0) begin
            c_n1.m  = c_n1.m << 16;
            c_n1.sc = c_n1.sc + 6'd16;
        end
        if (c_n1.m[M_W-1 -: 8] == '0) begin
            c_n1.m  = c_n1.m << 8;
            c_n1.sc = c_n1.sc + 6'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1.tag.vld <= 1'b0;
        end else if (i_en) begin
            r_n1 <= c_n1;
        end
    end

    // Normalisation, second half: shifts of 4, 2 and 1.
    t_lg r_n2, c_n2;
    always_comb begin
        c_n2 = r_n1;
        if (c_n2.m[M_W-1 -: 4] == '0) begin
            c_n2.m  = c_n2.m << 4;
            c_n2.sc = c_n2.sc + 6'd4;
        end
        if (c_n2.m[M_W-1 -: 2] == '0) begin
            c_n2.m  = c_n2.m << 2;
            c_n2.sc = c_n2.sc + 6'd2;
        end
        if (!c_n2.m[M_W-1]) begin
            c_n2.m  = c_n2.m << 1;
            c_n2.sc = c_n2.sc + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n2.tag.vld <= 1'b0;
        end else if (i_en) begin
            r_n2 <= c_n2;
        end
    end

    // Multiplicative steps: m grows towards 2, the sum collects the logs.
    t_lg r_it [ITER_STAGES];

    for (genvar s = 0; s < ITER_STAGES; s++) begin : g_iter
        t_lg         c_prev, c_next;
        logic [M_W:0] c_t;

        if (s == 0) begin : g_first
            assign c_prev = r_n2;
        end else begin : g_rest
            assign c_prev = r_it[s-1];
        end

        always_comb begin
            c_next = c_prev;
            c_t    = '0;
            for (int i = 0; i < STEPS_PER_STAGE; i++) begin
                c_t = {1'b0, c_next.m} + ({1'b0, c_next.m} >> (s * STEPS_PER_STAGE + i + 1));
                if (!c_t[M_W]) begin
                    c_next.m   = c_t[M_W-1:0];
                    c_next.sum = c_next.sum + w_chain[s * STEPS_PER_STAGE + i + 1][LN_TERMS];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it[s].tag.vld <= 1'b0;
            end else if (i_en) begin
                r_it[s] <= c_next;
            end
        end
    end

    // Mantissa log rounded to Q27, and the exponent term.
    t_tag               r_f1_tag;
    logic signed [31:0] r_f1_lnm;
    logic signed [33:0] r_f1_eprod;
    logic signed [65:0] c_v, c_vn;
    logic signed [31:0] c_lnm;
    logic signed [6:0]  c_e;

    always_comb begin
        c_v  = $signed({2'b00, LN2_Q62}) - $signed({2'b00, r_it[ITER_STAGES-1].sum})
               + $signed(LN_RND);
        c_vn = -c_v;
        if (c_v[65]) begin
            c_lnm = -$signed(32'(c_vn >> 35));
        end else begin
            c_lnm = $signed(32'(c_v >> 35));
        end
        c_e = $signed(7'(EXP_OFS)) - $signed({1'b0, r_it[ITER_STAGES-1].sc});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_f1_tag <= r_it[ITER_STAGES-1].tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_lnm   <= c_lnm;
            r_f1_eprod <= $signed(34'(c_e)) * $signed(34'({1'b0, LN2_Q27}));
        end
    end

    // Sum, sign and magnitude.
    logic signed [33:0] c_l;
    assign c_l = r_f1_eprod + 34'(r_f1_lnm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag.vld <= 1'b0;
        end else if (i_en) begin
            o_tag <= r_f1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_neg <= c_l[33];
            o_mag <= c_l[33] ? MAG_W'(-c_l) : MAG_W'(c_l);
        end
    end

endmodule

`default_nettype wire

// ----- sim/thdc_scoreboard.sv -----
// Scoreboard class for the thermistor conversion unit: temperature prediction and result checks.
`timescale 1ns / 100ps

class thdc_scoreboard;
    typedef struct {
        logic signed [16:0] temp;
        logic [1:0]         st;
    } t_reading;

    bit [19:0] divider;
    bit [31:0] coef_a;
    bit [31:0] coef_b;
    bit [31:0] coef_c;
    t_reading  pending[$];
    int        mismatches;

    function new();
        divider    = thdc_pkg::DIVIDER_RST;
        coef_a     = thdc_pkg::COEF_A_RST;
        coef_b     = thdc_pkg::COEF_B_RST;
        coef_c     = thdc_pkg::COEF_C_RST;
        mismatches = 0;
    endfunction

    function void set_reg(logic [3:0] idx, logic [31:0] val);
        case (idx)
            thdc_pkg::REG_DIVIDER: divider = val[19:0];
            thdc_pkg::REG_COEF_A:  coef_a  = val;
            thdc_pkg::REG_COEF_B:  coef_b  = val;
            thdc_pkg::REG_COEF_C:  coef_c  = val;
            default: ;
        endcase
    endfunction

    // Floor of a*b / 2^27, clamped to 64 bits.
    function bit [63:0] scaled_product(bit [63:0] a, bit [63:0] b);
        bit [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 27;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    // ln(1 + 2^-k) with 62 fraction bits from the truncated alternating series.
    function bit [63:0] log_step(int k);
        bit [63:0] acc;
        acc = 0;
        for (int n = 1; k * n <= 62; n++) begin
            if (n % 2) acc += (64'd1 << (62 - k * n)) / n;
            else       acc -= (64'd1 << (62 - k * n)) / n;
        end
        return acc;
    endfunction

    // Natural log of a resistance with 24 fraction bits, Q27 result.
    function longint log_q27(bit [63:0] r);
        int        p;
        bit [63:0] m, t, sum;
        longint    frac;
        p   = 61;
        sum = 0;
        while (p > 0 && r[p] == 1'b0) p--;
        m = r << (62 - p);
        for (int k = 1; k <= 30; k++) begin
            t = m + (m >> k);
            if (t[63] == 1'b0) begin
                m = t;
                sum += log_step(k);
            end
        end
        // Numerator is positive, so division truncation equals floor.
        frac = (longint'(thdc_pkg::LN2_Q62) - longint'(sum) + (64'sd1 <<< 34)) / (64'sd1 <<< 35);
        return longint'(p - 24) * 93032640 + frac;
    endfunction

    function t_reading convert(bit [12:0] supply, bit [12:0] rd);
        t_reading  res;
        bit [63:0] r, mag, bl, l2, l3, cl;
        longint    lnr, inv, temp;
        res.temp = 0;
        res.st   = thdc_pkg::ST_OK;
        if (rd == 0) begin
            res.st = thdc_pkg::ST_RD_ZERO;
            return res;
        end
        if (rd >= supply) begin
            res.st = thdc_pkg::ST_RD_HIGH;
            return res;
        end
        r = ((64'(divider) * 64'(supply - rd)) << 24) / 64'(rd);
        if (r == 0) begin
            res.temp = 17'sd65535;
            res.st   = thdc_pkg::ST_SAT;
            return res;
        end
        lnr = log_q27(r);
        mag = (lnr < 0) ? 64'(-lnr) : 64'(lnr);
        bl  = scaled_product(64'(coef_b), mag);
        l2  = scaled_product(mag, mag);
        l3  = scaled_product(l2, mag);
        cl  = scaled_product(64'(coef_c), l3);
        inv = longint'(coef_a);
        if (lnr < 0) inv -= longint'(bl) + longint'(cl);
        else         inv += longint'(bl) + longint'(cl);
        if (inv <= 0) begin
            temp   = 65535;
            res.st = thdc_pkg::ST_SAT;
        end else begin
            temp = longint'(((64'd100 << 40) + 64'(inv) / 2) / 64'(inv)) - 27315;
            if (temp > 65535) begin
                temp   = 65535;
                res.st = thdc_pkg::ST_SAT;
            end
        end
        res.temp = temp[16:0];
        return res;
    endfunction

    function void note_sample(bit [12:0] supply, bit [12:0] rd);
        pending.push_back(convert(supply, rd));
    endfunction

    function void check_reading(logic signed [16:0] temp, logic [1:0] st);
        t_reading want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: temp %0d status %0d", temp, st);
            return;
        end
        want = pending.pop_front();
        if (temp !== want.temp || st !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                         want.temp, want.st, temp, st);
        end
    endfunction
endclass

// ----- sim/tb.sv -----
// Testbench top: drives samples and register writes, checks every temperature result.
`timescale 1ns / 100ps

module tb;
    import thdc_pkg::*;

    // Settle time after the last result.
    localparam int SETTLE_CYCLES = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    thdc_cfg_if cfg_ch ();
    thdc_in_if  in_ch ();
    thdc_out_if out_ch ();

    thermistor_divider_to_celsius_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    thdc_scoreboard sb = new();
    bit             sink_on;

    always #5 i_clk = ~i_clk;

    initial begin
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.supply_mv  = '0;
        in_ch.read_mv    = '0;
        out_ch.ready     = 1'b0;
    end

    // Writes one register and mirrors it in the predictor once the transaction completes.
    // Valid drops for one cycle afterwards, so consecutive writes never collide.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one sample after a random gap; valid stays up across back-to-back transactions.
    task automatic send_sample(bit [12:0] supply, bit [12:0] rd, bit eager = 0);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.supply_mv <= supply;
        in_ch.read_mv   <= rd;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sample(supply, rd);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until all results are in, then lets the pipeline drain before any register write.
    task automatic drain();
        stop_sending();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Realistic sample: read below supply, most of the time; otherwise any 13-bit pattern.
    task automatic random_sample(bit burst);
        bit [12:0] s, r;
        if ($urandom_range(0, 9) < 8) begin
            s = 13'($urandom_range(2, 5000));
            r = 13'($urandom_range(1, s - 1));
        end else begin
            s = 13'($urandom());
            r = ($urandom_range(0, 3) == 0) ? 13'd0 : 13'($urandom());
        end
        send_sample(s, r, burst);
    endtask

    // Result side: random stalls per transaction, with stretches of full readiness.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_reading(out_ch.temp_centi_c, out_ch.status);
    end

    initial begin : sink_proc
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = sink_on ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Main sequence: directed corners, then several register settings with random traffic.
    initial begin : stim
        bit [31:0] a_set[4];
        bit [31:0] b_set[4];
        bit [31:0] c_set[4];
        bit [19:0] d_set[4];
        a_set = '{COEF_A_RST, 32'd0, 32'hFFFF_FFFF, 32'd1200000000};
        b_set = '{COEF_B_RST, 32'hFFFF_FFFF, 32'd0, 32'd250000000};
        c_set = '{COEF_C_RST, 32'd0, 32'hFFFF_FFFF, 32'd100000};
        d_set = '{DIVIDER_RST, 20'd1, 20'd1000000, 20'hFFFFF};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero read, read at and above supply, extremes of both fields.
        send_sample(13'd3300, 13'd0);
        send_sample(13'd3300, 13'd3300);
        send_sample(13'd1000, 13'd4000);
        send_sample(13'h1FFF, 13'h1FFF);
        send_sample(13'h1FFF, 13'd1);
        send_sample(13'h1FFF, 13'h1FFE);
        send_sample(13'd5000, 13'd1);
        send_sample(13'd5000, 13'd4999);
        send_sample(13'd3300, 13'd1650);
        send_sample(13'd2, 13'd1);
        send_sample(13'd0, 13'd0);
        send_sample(13'd1, 13'd0);
        drain();

        // Zero divider saturates high; then tiny divider and huge coefficients.
        write_reg(REG_DIVIDER, 32'd0);
        send_sample(13'd3300, 13'd1000);
        send_sample(13'd3300, 13'd0);
        drain();
        // Index past the register list must be ignored.
        write_reg(4'hF, 32'h1234_5678);
        write_reg(REG_DIVIDER, 32'd1);
        write_reg(REG_COEF_A, 32'd0);
        write_reg(REG_COEF_B, 32'hFFFF_FFFF);
        write_reg(REG_COEF_C, 32'hFFFF_FFFF);
        send_sample(13'd5000, 13'd4999);
        send_sample(13'd5000, 13'd1);
        send_sample(13'h1FFF, 13'd1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            int sel;
            sel = ph % 4;
            if (ph < 4) begin
                write_reg(REG_DIVIDER, 32'(d_set[sel]));
                write_reg(REG_COEF_A, a_set[sel]);
                write_reg(REG_COEF_B, b_set[sel]);
                write_reg(REG_COEF_C, c_set[sel]);
            end else begin
                write_reg(REG_DIVIDER, $urandom_range(0, 1000000));
                write_reg(REG_COEF_A, $urandom());
                write_reg(REG_COEF_B, $urandom());
                write_reg(REG_COEF_C, $urandom_range(0, 200000));
            end
            sink_on = (ph == 2);
            for (int i = 0; i < 225; i++)
                random_sample(ph == 2 || (i >= 100 && i < 140));
            drain();
        end

        sink_on = 1'b0;
        write_reg(REG_DIVIDER, 32'(DIVIDER_RST));
        write_reg(REG_COEF_A, COEF_A_RST);
        write_reg(REG_COEF_B, COEF_B_RST);
        write_reg(REG_COEF_C, COEF_C_RST);
        for (int i = 0; i < 50; i++) random_sample(1'b0);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
